### hdl/double_ended_queue_core_macros.svh
// Assertion macros for the double-ended queue core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define DQ_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dq_pkg.sv
// Shared types, constants and the ring index helper for the deque core.
// No dependencies.
`default_nettype none

package dq_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int ST_W        = 2;
  localparam int OCC_W       = 5;
  localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = OP_W;
  localparam int OUT_TDATA_W = ((DATA_W + OCC_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - OCC_W;
  localparam int OUT_TUSER_W = ST_W;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_DUMP
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_PUSH_FRONT,
    PTR_PUSH_REAR,
    PTR_POP_FRONT,
    PTR_POP_REAR
  } ptr_op_t;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_REAR,
    RD_DUMP
  } rd_sel_t;

  typedef struct packed {
    logic    in_load;
    ptr_op_t ptr_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    dump_clr;
    logic    dump_inc;
    logic    out_load;
    logic    out_zero;
    st_t     out_status;
    logic    out_last;
  } dq_cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic dump_last;
    logic out_free;
  } dq_stat_t;

  // front + offset wrapped into the ring; offset stays below DEPTH
  function automatic idx_t ring_pos(idx_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return idx_t'(sum);
  endfunction

endpackage

`default_nettype wire

### hdl/dq_ctrl.sv
// Controller for the deque core: request decode and dump sequencing.
// Depends on dq_pkg; drives dq_dpath through dq_cmd_t.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dq_stat_t stat,
  output dq_cmd_t  cmd
);

  state_t state_r, state_nxt;
  st_t    res_status_r, res_status_nxt;
  logic   res_zero_r, res_zero_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_status_r <= ST_OK;
      res_zero_r   <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      res_zero_r   <= res_zero_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_zero_nxt   = res_zero_r;
    in_tready      = 1'b0;
    cmd.in_load    = 1'b0;
    cmd.ptr_op     = PTR_HOLD;
    cmd.rd_en      = 1'b0;
    cmd.rd_sel     = RD_FRONT;
    cmd.dump_clr   = 1'b0;
    cmd.dump_inc   = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.out_zero   = 1'b1;
    cmd.out_status = ST_OK;
    cmd.out_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        // no word is taken while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt      = S_EMIT;
        res_status_nxt = ST_OK;
        res_zero_nxt   = 1'b1;
        unique case (stat.op) inside
          OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (stat.full) begin
              res_status_nxt = ST_FULL;
            end else begin
              cmd.ptr_op = (stat.op == OP_PUSH_FRONT) ? PTR_PUSH_FRONT : PTR_PUSH_REAR;
            end
          end
          OP_POP_FRONT, OP_POP_REAR: begin
            if (stat.empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = (stat.op == OP_POP_FRONT) ? RD_FRONT : RD_REAR;
              cmd.ptr_op   = (stat.op == OP_POP_FRONT) ? PTR_POP_FRONT : PTR_POP_REAR;
              res_zero_nxt = 1'b0;
            end
          end
          OP_DUMP: begin
            if (stat.empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.rd_sel   = RD_DUMP;
              cmd.dump_clr = 1'b1;
              state_nxt    = S_DUMP;
            end
          end
          default: begin
            // unknown request: plain ok word, nothing touched
          end
        endcase
      end

      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_zero   = res_zero_r;
          cmd.out_status = res_status_r;
          in_tready      = 1'b1;
          cmd.in_load    = in_tvalid;
          state_nxt      = in_tvalid ? S_EXEC : S_IDLE;
        end
      end

      S_DUMP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = 1'b0;
          cmd.out_last = stat.dump_last;
          if (stat.dump_last) begin
            in_tready   = 1'b1;
            cmd.in_load = in_tvalid;
            state_nxt   = in_tvalid ? S_EXEC : S_IDLE;
          end else begin
            // prefetch the next entry while this word goes out
            cmd.dump_inc = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_DUMP;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/dq_dpath.sv
// Datapath for the deque core: ring store, front/count pointers,
// dump index and the output register. Depends on dq_pkg.
`default_nettype none

module dq_dpath
  import dq_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  dq_cmd_t         cmd,
  input  logic [OP_W-1:0] in_op,
  input  data_t           in_value,
  input  logic            out_tready,
  output dq_stat_t        stat,
  output logic            out_tvalid,
  output data_t           out_value,
  output st_t             out_status,
  output logic            out_last,
  output logic [OCC_W-1:0] out_occ
);

  data_t item_mem [DEPTH];

  op_t   op_r;
  data_t value_r;
  data_t rd_data_r;
  idx_t  front_r, front_nxt;
  cnt_t  count_r, count_nxt;
  cnt_t  dump_idx_r, dump_idx_nxt;
  logic  out_v_r, out_v_nxt;
  data_t out_value_r;
  st_t   out_status_r;
  logic  out_last_r;
  logic [OCC_W-1:0] out_occ_r;

  idx_t  front_dec, front_inc;
  idx_t  wr_addr, rd_addr;
  logic  mem_wr;
  logic  out_free;

  assign front_dec = (front_r == '0) ? idx_t'(DEPTH - 1) : front_r - idx_t'(1);
  assign front_inc = (front_r == idx_t'(DEPTH - 1)) ? '0 : front_r + idx_t'(1);

  assign mem_wr  = (cmd.ptr_op == PTR_PUSH_FRONT) || (cmd.ptr_op == PTR_PUSH_REAR);
  assign wr_addr = (cmd.ptr_op == PTR_PUSH_FRONT) ? front_dec : ring_pos(front_r, count_r);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    case (cmd.ptr_op)
      PTR_PUSH_FRONT: begin
        front_nxt = front_dec;
        count_nxt = count_r + cnt_t'(1);
      end
      PTR_PUSH_REAR: begin
        count_nxt = count_r + cnt_t'(1);
      end
      PTR_POP_FRONT: begin
        front_nxt = front_inc;
        count_nxt = count_r - cnt_t'(1);
      end
      PTR_POP_REAR: begin
        count_nxt = count_r - cnt_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd.dump_clr) begin
      dump_idx_nxt = '0;
    end else if (cmd.dump_inc) begin
      dump_idx_nxt = dump_idx_r + cnt_t'(1);
    end else begin
      dump_idx_nxt = dump_idx_r;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_FRONT: rd_addr = front_r;
      RD_REAR:  rd_addr = ring_pos(front_r, count_r - cnt_t'(1));
      default:  rd_addr = ring_pos(front_r, dump_idx_nxt);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      item_mem[wr_addr] <= value_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= item_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_r    <= op_t'(in_op);
      value_r <= in_value;
    end
    if (cmd.out_load) begin
      out_value_r  <= cmd.out_zero ? '0 : rd_data_r;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
      out_occ_r    <= OCC_W'(count_r);
    end
  end

  assign out_free  = !out_v_r || out_tready;
  assign out_v_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r    <= '0;
      count_r    <= '0;
      dump_idx_r <= '0;
      out_v_r    <= 1'b0;
    end else begin
      front_r    <= front_nxt;
      count_r    <= count_nxt;
      dump_idx_r <= dump_idx_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  assign stat.op        = op_r;
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == cnt_t'(DEPTH));
  assign stat.dump_last = ((dump_idx_r + cnt_t'(1)) == count_r);
  assign stat.out_free  = out_free;

  assign out_tvalid = out_v_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;
  assign out_occ    = out_occ_r;

endmodule

`default_nettype wire

### hdl/double_ended_queue_core.sv
// Top level of the bounded double-ended queue core.
// Depends on dq_pkg, dq_ctrl, dq_dpath and double_ended_queue_core_macros.svh.
//
//   channel  dir  word contents
//   in_      in   tuser: op; tdata: item_value
//   out_     out  tuser: status; tdata: result_value, occupancy; tlast: last_of_run
//
// Push, pop and unknown requests pass through an execute state against the store
// and an emit state that loads the output register while the next word comes in.
// A dump of N items reads the store once per word through the registered read
// port. Reset clears pointers and count; store contents are kept.
// With out_tready low the output word holds and in_tready drops once the
// controller has a result waiting.
`default_nettype none
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core
  import dq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] item_value
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [2:0] op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] result_value, [36:32] occupancy
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [1:0] status
  output logic                   out_tlast
);

  dq_cmd_t          cmd;
  dq_stat_t         stat;
  data_t            out_value;
  st_t              out_status;
  logic [OCC_W-1:0] out_occ;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dq_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_tuser[OP_W-1:0]),
    .in_value   (data_t'(in_tdata[DATA_W-1:0])),
    .out_tready (out_tready),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_value  (out_value),
    .out_status (out_status),
    .out_last   (out_tlast),
    .out_occ    (out_occ)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_occ, out_value};
  assign out_tuser = out_status;

  `DQ_ASSERT_IMPL(a_full_occ, out_tvalid && (out_tuser == ST_FULL), out_tdata[DATA_W+OCC_W-1:DATA_W] == OCC_W'(DEPTH), "full word without full occupancy")
  `DQ_ASSERT_IMPL(a_empty_word, out_tvalid && (out_tuser == ST_EMPTY), (out_tdata[DATA_W+OCC_W-1:DATA_W] == '0) && (out_tdata[DATA_W-1:0] == '0), "empty word not zero")
  `DQ_ASSERT_IMPL(a_mid_dump_ok, out_tvalid && !out_tlast, out_tuser == ST_OK, "non-final word without ok status")
  `DQ_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "request accepted while executing")

endmodule

`default_nettype wire
